// ===== hw/rtl/cpdp_pkg.sv =====
// Shared types, widths and codes of the point cloud depth projection unit.
package cpdp_pkg;

  localparam int MAX_IMAGE_DEF = 128;
  localparam int MIN_IMAGE     = 16;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 24;
  localparam int LEN_W   = 23;
  localparam int VIEW_W  = 2;
  localparam int ISZ_W   = 8;
  localparam int DEPTH_W = 17;
  localparam int PIX_W   = 7;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE = 17'h10000;

  localparam int SCALE_W     = 32;
  localparam int OPD_W       = POS_W + 3;
  localparam int PROD_W      = OPD_W + SCALE_W + 1;
  localparam int FRAC_SHIFT  = 24;
  localparam int ROUND_SHIFT = 25;
  localparam int DEPTH_SHIFT = 17;
  localparam int RECIP_SHIFT = 32;

  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = LEN_W + 1;

  // floor(x/10) as (x*205)>>11, exact well beyond any image size
  localparam int PAD_MUL   = 205;
  localparam int PAD_SHIFT = 11;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [LEN_W-1:0] BOX_LEN_RST = 23'd4096;
  localparam logic [ISZ_W-1:0] IMAGE_RST   = 8'd128;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR,
    CMD_POINT,
    CMD_JOINT,
    CMD_READ
  } cmd_t;

  typedef enum logic [VIEW_W-1:0] {
    VIEW_XY,
    VIEW_YZ,
    VIEW_ZX
  } view_t;

  typedef enum logic [2:0] {
    REG_VIEW,
    REG_LEN_X,
    REG_LEN_Y,
    REG_LEN_Z,
    REG_SIZE
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SWEEP,
    ST_MUL_U,
    ST_MUL_V,
    ST_MUL_D,
    ST_MEM_RD,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_RATIO,
    DIV_SCALE,
    DIV_RECIP
  } div_sel_t;

  typedef enum logic [1:0] {
    MUL_U,
    MUL_V,
    MUL_D
  } mul_sel_t;

  typedef struct packed {
    logic [VIEW_W-1:0] view_select;
    logic [LEN_W-1:0]  box_len_x;
    logic [LEN_W-1:0]  box_len_y;
    logic [LEN_W-1:0]  box_len_z;
    logic [ISZ_W-1:0]  image_size;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     prod_en;
    logic     lat_u;
    logic     lat_v;
    logic     lat_d;
    logic     mem_rd;
    logic     div_start;
    logic     div_latch;
    div_sel_t div_sel;
    logic     sweep_en;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/cpdp_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface cpdp_in_if;
  import cpdp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [PIX_W-1:0]        read_row;
  logic [PIX_W-1:0]        read_col;

  modport source (output valid, cmd, pos_x, pos_y, pos_z, read_row, read_col, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pos_z, read_row, read_col, output ready);
endinterface

interface cpdp_out_if;
  import cpdp_pkg::*;
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_out;
  logic [PIX_W-1:0]   pix_u;
  logic [PIX_W-1:0]   pix_v;
  logic               updated;

  modport source (output valid, depth_out, pix_u, pix_v, updated, input ready);
  modport sink (input valid, depth_out, pix_u, pix_v, updated, output ready);
endinterface

// ===== hw/rtl/cpdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpdp_ram #(
  parameter int WIDTH = cpdp_pkg::DEPTH_W,
  parameter int DEPTH = cpdp_pkg::MAX_IMAGE_DEF * cpdp_pkg::MAX_IMAGE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/cpdp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module cpdp_div #(
  parameter int NUM_W = cpdp_pkg::DIV_NUM_W,
  parameter int DEN_W = cpdp_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // The numerator shifts out of the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== hw/rtl/cpdp_ctrl.sv =====
// Sequencing state machine of the depth projection unit.
module cpdp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  cpdp_pkg::cmd_t         in_cmd,
  output logic                   in_ready,
  input  cpdp_pkg::dp_status_t   status,
  output cpdp_pkg::ctrl_cmd_t    cmd
);
  import cpdp_pkg::*;

  state_t   state_r, state_nxt;
  div_sel_t div_sel_r, div_sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      div_sel_r <= DIV_RATIO;
    end else begin
      state_r   <= state_nxt;
      div_sel_r <= div_sel_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_sel_nxt = div_sel_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.div_sel = div_sel_r;
    cmd.mul_sel = MUL_U;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_cmd)
            CMD_CLEAR: begin
              div_sel_nxt = DIV_RATIO;
              state_nxt   = ST_DIV_START;
            end
            CMD_POINT, CMD_JOINT: state_nxt = ST_MUL_U;
            CMD_READ:             state_nxt = ST_MEM_RD;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_latch = 1'b1;
          if (div_sel_r == DIV_RECIP) begin
            state_nxt = ST_SWEEP;
          end else begin
            div_sel_nxt = (div_sel_r == DIV_RATIO) ? DIV_SCALE : DIV_RECIP;
            state_nxt   = ST_DIV_START;
          end
        end
      end
      ST_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MUL_U: begin
        cmd.mul_sel = MUL_U;
        cmd.prod_en = 1'b1;
        state_nxt   = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd.mul_sel = MUL_V;
        cmd.prod_en = 1'b1;
        cmd.lat_u   = 1'b1;
        state_nxt   = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_sel = MUL_D;
        cmd.prod_en = 1'b1;
        cmd.lat_v   = 1'b1;
        state_nxt   = ST_MEM_RD;
      end
      ST_MEM_RD: begin
        cmd.lat_d  = 1'b1;
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/cpdp_dp.sv =====
// Datapath: axis selection, shared multiplier, divider, depth memory and result register.
module cpdp_dp #(
  parameter int MAX_IMAGE = cpdp_pkg::MAX_IMAGE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cpdp_pkg::cfg_t                       cfg,
  input  cpdp_pkg::ctrl_cmd_t                  cmd,
  output cpdp_pkg::dp_status_t                 status,
  input  logic [cpdp_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [cpdp_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [cpdp_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [cpdp_pkg::POS_W-1:0]    in_pos_z,
  input  logic [cpdp_pkg::PIX_W-1:0]           in_read_row,
  input  logic [cpdp_pkg::PIX_W-1:0]           in_read_col,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [cpdp_pkg::DEPTH_W-1:0]         out_depth_out,
  output logic [cpdp_pkg::PIX_W-1:0]           out_pix_u,
  output logic [cpdp_pkg::PIX_W-1:0]           out_pix_v,
  output logic                                 out_updated
);
  import cpdp_pkg::*;

  localparam int CW    = $clog2(MAX_IMAGE);
  localparam int SW    = CW + 1;
  localparam int PW    = SW + 8;
  localparam int DEPTH = MAX_IMAGE * MAX_IMAGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = PROD_W - ROUND_SHIFT;
  localparam int TW    = RW + 1;
  localparam int HW    = PROD_W - 1 - DEPTH_SHIFT;

  // Captured item
  cmd_t                    cmd_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [PIX_W-1:0]        row_r, col_r;

  // State left by the last clear
  logic [SW-1:0]      region_w_r, region_h_r;
  logic [CW-1:0]      region_left_r, region_top_r;
  logic [SCALE_W-1:0] scale_r, recip_r;

  logic signed [PROD_W-1:0] prod_r;
  logic [CW-1:0]            coord_u_r, coord_v_r;
  logic [DEPTH_W-1:0]       nd_r;
  logic [AW-1:0]            addr_r;
  logic                     oob_r;
  logic [AW-1:0]            sweep_cnt_r;
  logic                     out_valid_r;
  logic [DEPTH_W-1:0]       depth_out_r;
  logic [PIX_W-1:0]         pix_u_r, pix_v_r;
  logic                     updated_r;

  logic [LEN_W-1:0]         lx, ly, lz, la, lb, ld, big, small_len;
  logic signed [POS_W:0]    px, py, pz, pu, pv, pq;
  logic                     la_ge;
  logic [SW-1:0]            sz, pad, m, wn, hn, qs;
  logic [PW-1:0]            pad_prod;
  logic signed [OPD_W-1:0]  opa;
  logic [SCALE_W-1:0]       opb;
  logic signed [PROD_W-1:0] prod;
  logic [DIV_NUM_W-1:0]     div_num, div_quo;
  logic [DIV_DEN_W-1:0]     div_den;
  logic                     div_done;
  logic [AW-1:0]            rd_addr, waddr;
  logic [DEPTH_W-1:0]       rdata, wdata;
  logic                     we, smaller, rd_oob;

  function automatic logic signed [OPD_W-1:0] mk_opd(input logic signed [POS_W:0] p,
                                                     input logic [LEN_W-1:0] l);
    return {p[POS_W], p, 1'b0} + $signed({{(OPD_W-LEN_W){1'b0}}, l});
  endfunction

  // Magnitude rounded half away from zero at the scale point
  function automatic logic [RW-1:0] round_mag(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] s;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    s   = mag + (PROD_W'(1) << (ROUND_SHIFT - 1));
    return s[PROD_W-1:ROUND_SHIFT];
  endfunction

  // Points are clamped inside the region, joints inside the whole image.
  function automatic logic [CW-1:0] place(input logic signed [PROD_W-1:0] p,
                                          input logic [SW-1:0] size,
                                          input logic [CW-1:0] origin,
                                          input logic [SW-1:0] img,
                                          input logic joint);
    logic [RW-1:0] r;
    logic          neg;
    logic [RW-1:0] hi;
    logic [RW-1:0] loc;
    logic [TW-1:0] t;
    logic [TW-1:0] lim;
    logic [CW-1:0] res;
    r   = round_mag(p);
    neg = p[PROD_W-1];
    if (joint) begin
      lim = TW'(img) - 1'b1;
      // The origin of an older clear may lie beyond the current image.
      if (neg) begin
        if (r > RW'(origin)) begin
          t = '0;
        end else begin
          t = TW'(RW'(origin) - r);
        end
      end else begin
        t = TW'(r) + TW'(origin);
      end
      res = (t > lim) ? CW'(lim) : CW'(t);
    end else begin
      hi  = (size == '0) ? '0 : RW'(size - 1'b1);
      loc = neg ? '0 : ((r > hi) ? hi : r);
      t   = TW'(loc) + TW'(origin);
      lim = TW'(MAX_IMAGE - 1);
      res = (t > lim) ? CW'(lim) : CW'(t);
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] pix_addr(input int row, input int col);
    return AW'(row * MAX_IMAGE + col);
  endfunction

  function automatic logic [SCALE_W-1:0] sat32(input logic [DIV_NUM_W-1:0] q);
    return (q[DIV_NUM_W-1:SCALE_W] != '0) ? '1 : q[SCALE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= cmd_t'(in_cmd);
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      row_r   <= in_read_row;
      col_r   <= in_read_col;
    end
  end

  // Axes of the current view; a zero length counts as one.
  always_comb begin
    lx = (cfg.box_len_x == '0) ? LEN_W'(1) : cfg.box_len_x;
    ly = (cfg.box_len_y == '0) ? LEN_W'(1) : cfg.box_len_y;
    lz = (cfg.box_len_z == '0) ? LEN_W'(1) : cfg.box_len_z;
    px = {pos_x_r[POS_W-1], pos_x_r};
    py = {pos_y_r[POS_W-1], pos_y_r};
    pz = {pos_z_r[POS_W-1], pos_z_r};
    case (cfg.view_select)
      VIEW_YZ: begin
        la = ly; lb = lz; ld = lx; pu = -py; pv = pz; pq = -px;
      end
      VIEW_ZX: begin
        la = lz; lb = lx; ld = ly; pu = pz; pv = px; pq = -py;
      end
      default: begin
        la = lx; lb = ly; ld = lz; pu = px; pv = -py; pq = pz;
      end
    endcase
    la_ge     = la >= lb;
    big       = la_ge ? la : lb;
    small_len = la_ge ? lb : la;
  end

  always_comb begin
    if (cfg.image_size < ISZ_W'(MIN_IMAGE)) begin
      sz = SW'(MIN_IMAGE);
    end else if (int'(cfg.image_size) > MAX_IMAGE) begin
      sz = SW'(MAX_IMAGE);
    end else begin
      sz = SW'(cfg.image_size);
    end
    pad_prod = PW'(sz) * PW'(PAD_MUL);
    pad      = SW'(pad_prod >> PAD_SHIFT);
    m        = sz - SW'(pad << 1);
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_RATIO: begin
        div_num = ((DIV_NUM_W'(m) * DIV_NUM_W'(small_len)) << 1) + DIV_NUM_W'(big);
        div_den = DIV_DEN_W'({big, 1'b0});
      end
      DIV_SCALE: begin
        div_num = (DIV_NUM_W'(m) << FRAC_SHIFT) + DIV_NUM_W'(big >> 1);
        div_den = DIV_DEN_W'(big);
      end
      default: begin
        div_num = (DIV_NUM_W'(1) << RECIP_SHIFT) + DIV_NUM_W'(ld >> 1);
        div_den = DIV_DEN_W'(ld);
      end
    endcase
  end

  cpdp_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    qs = SW'(div_quo);
    wn = la_ge ? m : qs;
    hn = la_ge ? qs : m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_w_r    <= '0;
      region_h_r    <= '0;
      region_left_r <= '0;
      region_top_r  <= '0;
      scale_r       <= '0;
      recip_r       <= '0;
    end else if (cmd.div_latch) begin
      case (cmd.div_sel)
        DIV_RATIO: begin
          region_w_r    <= wn;
          region_h_r    <= hn;
          region_left_r <= CW'((sz - wn) >> 1);
          region_top_r  <= CW'((sz - hn) >> 1);
        end
        DIV_SCALE: scale_r <= sat32(div_quo);
        default:   recip_r <= sat32(div_quo);
      endcase
    end
  end

  // One multiplier serves the column, the row and the depth in turn.
  always_comb begin
    case (cmd.mul_sel)
      MUL_U: begin
        opa = mk_opd(pu, la);
        opb = scale_r;
      end
      MUL_V: begin
        opa = mk_opd(pv, lb);
        opb = scale_r;
      end
      default: begin
        opa = mk_opd(pq, ld);
        opb = recip_r;
      end
    endcase
    prod = opa * $signed({1'b0, opb});
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod_r <= prod;
    end
    if (cmd.lat_u) begin
      coord_u_r <= place(prod_r, region_w_r, region_left_r, sz, cmd_r == CMD_JOINT);
    end
    if (cmd.lat_v) begin
      coord_v_r <= place(prod_r, region_h_r, region_top_r, sz, cmd_r == CMD_JOINT);
    end
    if (cmd.lat_d) begin
      if (prod_r[PROD_W-1]) begin
        nd_r <= '0;
      end else if (prod_r[PROD_W-2:DEPTH_SHIFT] > HW'(DEPTH_ONE)) begin
        nd_r <= DEPTH_ONE;
      end else begin
        nd_r <= prod_r[DEPTH_SHIFT+DEPTH_W-1:DEPTH_SHIFT];
      end
    end
    if (cmd.mem_rd) begin
      addr_r <= rd_addr;
      oob_r  <= rd_oob;
    end
  end

  always_comb begin
    rd_oob = (int'(row_r) >= MAX_IMAGE) || (int'(col_r) >= MAX_IMAGE);
    if (cmd_r == CMD_READ) begin
      rd_addr = pix_addr(int'(row_r), int'(col_r));
    end else begin
      rd_addr = pix_addr(int'(coord_v_r), int'(coord_u_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep_en) begin
      sweep_cnt_r <= status.sweep_last ? '0 : sweep_cnt_r + 1'b1;
    end
  end

  always_comb begin
    smaller = rdata > nd_r;
    we      = cmd.sweep_en || (cmd.out_load && (cmd_r == CMD_POINT) && smaller);
    waddr   = cmd.sweep_en ? sweep_cnt_r : addr_r;
    wdata   = cmd.sweep_en ? DEPTH_ONE : nd_r;
  end

  cpdp_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (DEPTH)
  ) u_depth_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.mem_rd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd_r)
        CMD_CLEAR: begin
          depth_out_r <= DEPTH_ONE;
          pix_u_r     <= '0;
          pix_v_r     <= '0;
          updated_r   <= 1'b0;
        end
        CMD_POINT: begin
          depth_out_r <= smaller ? nd_r : rdata;
          pix_u_r     <= PIX_W'(coord_u_r);
          pix_v_r     <= PIX_W'(coord_v_r);
          updated_r   <= smaller;
        end
        CMD_JOINT: begin
          depth_out_r <= '0;
          pix_u_r     <= PIX_W'(coord_u_r);
          pix_v_r     <= PIX_W'(coord_v_r);
          updated_r   <= 1'b0;
        end
        default: begin
          depth_out_r <= oob_r ? DEPTH_ONE : rdata;
          pix_u_r     <= col_r;
          pix_v_r     <= row_r;
          updated_r   <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    status.div_done   = div_done;
    status.sweep_last = sweep_cnt_r == AW'(DEPTH - 1);
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_depth_out = depth_out_r;
  assign out_pix_u     = pix_u_r;
  assign out_pix_v     = pix_v_r;
  assign out_updated   = updated_r;
endmodule

// ===== hw/rtl/point_cloud_depth_projection_unit.sv =====
// Top level of the point cloud depth projection unit: register port, controller and datapath.
//
// Box-frame points arrive as beats on in_ch (valid/ready); each accepted beat gives exactly
// one result beat on out_ch. A clear beat fills the depth image with 1.0 and fits the region,
// a point beat keeps the nearest depth at its pixel, a joint beat returns image coordinates
// and a read beat returns one stored pixel. Items are worked on one at a time: a point or
// joint passes through the states MUL_U, MUL_V, MUL_D, MEM_RD and FINISH before the next
// is accepted, and a read through MEM_RD and FINISH. A point or joint uses the single shared
// multiplier for column, row and depth in turn, and a point then reads and writes the depth
// memory; a clear runs the ratio, scale and reciprocal divisions on the bit-serial divider
// and then fills the memory, one pixel per cycle. After reset the block runs a clearing pass
// over all MAX_IMAGE*MAX_IMAGE (16384) words of the depth memory and holds in_ch.ready low
// until it ends; register writes are taken meanwhile. The result sits in an output register:
// the next item is accepted while it waits, and a stalled receiver only holds the block at
// the point where a further result is due. The user must write registers over the APB port
// only while the block is idle; the block itself does not enforce it.
module point_cloud_depth_projection_unit #(
  parameter int MAX_IMAGE = cpdp_pkg::MAX_IMAGE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cpdp_in_if.sink                        in_ch,
  cpdp_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpdp_pkg::PADDR_W-1:0]   paddr,
  input  logic [cpdp_pkg::PDATA_W-1:0]   pwdata,
  output logic [cpdp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import cpdp_pkg::*;

  cfg_t       cfg_r;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  reg_idx_t   reg_idx;
  logic       cfg_wr;
  logic       in_ready;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.view_select <= VIEW_XY;
      cfg_r.box_len_x   <= BOX_LEN_RST;
      cfg_r.box_len_y   <= BOX_LEN_RST;
      cfg_r.box_len_z   <= BOX_LEN_RST;
      cfg_r.image_size  <= IMAGE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_VIEW:  cfg_r.view_select <= pwdata[VIEW_W-1:0];
        REG_LEN_X: cfg_r.box_len_x   <= pwdata[LEN_W-1:0];
        REG_LEN_Y: cfg_r.box_len_y   <= pwdata[LEN_W-1:0];
        REG_LEN_Z: cfg_r.box_len_z   <= pwdata[LEN_W-1:0];
        REG_SIZE:  cfg_r.image_size  <= pwdata[ISZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VIEW:  prdata = PDATA_W'(cfg_r.view_select);
      REG_LEN_X: prdata = PDATA_W'(cfg_r.box_len_x);
      REG_LEN_Y: prdata = PDATA_W'(cfg_r.box_len_y);
      REG_LEN_Z: prdata = PDATA_W'(cfg_r.box_len_z);
      REG_SIZE:  prdata = PDATA_W'(cfg_r.image_size);
      default:   prdata = '0;
    endcase
  end

  cpdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (cmd_t'(in_ch.cmd)),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  assign in_ch.ready = in_ready;

  cpdp_dp #(
    .MAX_IMAGE (MAX_IMAGE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (ctrl_cmd),
    .status        (dp_status),
    .in_cmd        (in_ch.cmd),
    .in_pos_x      (in_ch.pos_x),
    .in_pos_y      (in_ch.pos_y),
    .in_pos_z      (in_ch.pos_z),
    .in_read_row   (in_ch.read_row),
    .in_read_col   (in_ch.read_col),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_depth_out (out_ch.depth_out),
    .out_pix_u     (out_ch.pix_u),
    .out_pix_v     (out_ch.pix_v),
    .out_updated   (out_ch.updated)
  );

`ifndef SYNTH
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.sweep_en |-> !in_ready)
    else $error("input taken while the depth memory is being cleared");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.out_load |-> dp_status.out_free)
    else $error("result register loaded while a result beat is still pending");

  a_div_latch_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.div_latch |-> dp_status.div_done)
    else $error("divider result latched before the division finished");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("second input beat accepted straight after the first");
`endif
endmodule

// ===== sim/cpdp_depth_checker.sv =====
// Watches the channels and the register port, predicts every result beat and compares it.
module cpdp_depth_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  cpdp_in_if                             in_ch,
  cpdp_out_if                            out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpdp_pkg::PADDR_W-1:0]   paddr,
  input  logic [cpdp_pkg::PDATA_W-1:0]   pwdata,
  input  logic                           pready,
  output int                             mismatch_count,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpdp_pkg::*;

  localparam int IMG = MAX_IMAGE_DEF;

  typedef struct {
    logic [DEPTH_W-1:0] depth;
    logic [PIX_W-1:0]   u;
    logic [PIX_W-1:0]   v;
    logic               updated;
  } pixel_beat_t;

  pixel_beat_t pixel_queue[$];
  logic [DEPTH_W-1:0] depth_image [0:IMG*IMG-1];
  longint reg_w, reg_h, reg_left, reg_top;
  logic [SCALE_W-1:0] px_scale, z_recip;

  logic [VIEW_W-1:0] cur_view;
  logic [LEN_W-1:0]  len_x, len_y, len_z;
  logic [ISZ_W-1:0]  img_size;
  int errs;

  function automatic longint side_px();
    longint s;
    s = longint'(img_size);
    if (s < MIN_IMAGE) s = MIN_IMAGE;
    if (s > IMG) s = IMG;
    return s;
  endfunction

  function automatic longint nz(logic [LEN_W-1:0] l);
    return (l == '0) ? 64'sd1 : longint'({41'd0, l});
  endfunction

  // Picks the lengths and coordinates along u, v and depth for the selected plane.
  task automatic view_axes(input longint x, input longint y, input longint z,
                           output longint la, output longint lb, output longint ld,
                           output longint pu, output longint pv, output longint pq);
    case (cur_view)
      VIEW_YZ: begin
        la = nz(len_y); lb = nz(len_z); ld = nz(len_x); pu = -y; pv = z; pq = -x;
      end
      VIEW_ZX: begin
        la = nz(len_z); lb = nz(len_x); ld = nz(len_y); pu = z; pv = x; pq = -y;
      end
      default: begin
        la = nz(len_x); lb = nz(len_y); ld = nz(len_z); pu = x; pv = -y; pq = z;
      end
    endcase
  endtask

  function automatic longint to_pixel(longint p, longint len);
    longint prod, mag, r;
    prod = longint'({32'd0, px_scale}) * (2 * p + len);
    mag = (prod < 0) ? -prod : prod;
    r = (mag + (64'sd1 <<< FRAC_SHIFT)) >>> ROUND_SHIFT;
    return (prod < 0) ? -r : r;
  endfunction

  function automatic longint clamp_to(longint v, longint size);
    longint hi;
    hi = (size > 0) ? size - 1 : 0;
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [SCALE_W-1:0] sat32(longint v);
    return (v > 64'sh0FFFF_FFFF) ? '1 : v[SCALE_W-1:0];
  endfunction

  task automatic project_item(input logic [CMD_W-1:0] c, input longint x, input longint y,
                              input longint z, input int row, input int col,
                              output pixel_beat_t res);
    longint la, lb, ld, pu, pv, pq, sz, m, fill, u, v, t, nd, pc, pr;
    res = '{depth: '0, u: '0, v: '0, updated: 1'b0};
    view_axes(x, y, z, la, lb, ld, pu, pv, pq);
    sz = side_px();
    case (cmd_t'(c))
      CMD_CLEAR: begin
        foreach (depth_image[i]) depth_image[i] = DEPTH_ONE;
        m = sz - 2 * (sz / 10);
        if (la >= lb) begin
          reg_w = m; reg_h = (2 * m * lb + la) / (2 * la); fill = la;
        end else begin
          reg_h = m; reg_w = (2 * m * la + lb) / (2 * lb); fill = lb;
        end
        reg_left = (sz - reg_w) >>> 1;
        reg_top = (sz - reg_h) >>> 1;
        px_scale = sat32(((m <<< FRAC_SHIFT) + fill / 2) / fill);
        z_recip = sat32(((64'sd1 <<< RECIP_SHIFT) + ld / 2) / ld);
        res.depth = DEPTH_ONE;
      end
      CMD_POINT: begin
        u = clamp_to(to_pixel(pu, la), reg_w);
        v = clamp_to(to_pixel(pv, lb), reg_h);
        t = (2 * pq + ld) * longint'({32'd0, z_recip});
        nd = (t < 0) ? 0 : (t >>> DEPTH_SHIFT);
        if (nd > DEPTH_ONE) nd = DEPTH_ONE;
        pc = u + reg_left;
        pr = v + reg_top;
        if (pc >= IMG) pc = IMG - 1;
        if (pr >= IMG) pr = IMG - 1;
        if (depth_image[pr * IMG + pc] > nd) begin
          depth_image[pr * IMG + pc] = nd[DEPTH_W-1:0];
          res.updated = 1'b1;
        end
        res.depth = depth_image[pr * IMG + pc];
        res.u = pc[PIX_W-1:0];
        res.v = pr[PIX_W-1:0];
      end
      CMD_JOINT: begin
        u = clamp_to(to_pixel(pu, la) + reg_left, sz);
        v = clamp_to(to_pixel(pv, lb) + reg_top, sz);
        res.u = u[PIX_W-1:0];
        res.v = v[PIX_W-1:0];
      end
      default: begin
        res.depth = depth_image[row * IMG + col];
        res.u = col[PIX_W-1:0];
        res.v = row[PIX_W-1:0];
      end
    endcase
  endtask

  always @(posedge clk) begin
    pixel_beat_t want, got;
    if (!rst_n) begin
      foreach (depth_image[i]) depth_image[i] = DEPTH_ONE;
      reg_w = 0; reg_h = 0; reg_left = 0; reg_top = 0;
      px_scale = '0; z_recip = '0;
      cur_view = VIEW_XY;
      len_x = BOX_LEN_RST; len_y = BOX_LEN_RST; len_z = BOX_LEN_RST;
      img_size = IMAGE_RST;
      pixel_queue.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_VIEW:  cur_view = pwdata[VIEW_W-1:0];
          REG_LEN_X: len_x = pwdata[LEN_W-1:0];
          REG_LEN_Y: len_y = pwdata[LEN_W-1:0];
          REG_LEN_Z: len_z = pwdata[LEN_W-1:0];
          REG_SIZE:  img_size = pwdata[ISZ_W-1:0];
          default: ;
        endcase
      end
      // The result beat belongs to an older item than any beat accepted at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        got = '{depth: out_ch.depth_out, u: out_ch.pix_u, v: out_ch.pix_v,
                updated: out_ch.updated};
        if (pixel_queue.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result beat with nothing pending: depth %0d u %0d v %0d upd %0d",
                     $time, got.depth, got.u, got.v, got.updated);
        end else begin
          want = pixel_queue.pop_front();
          if (got.depth !== want.depth || got.u !== want.u || got.v !== want.v ||
              got.updated !== want.updated) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch: want depth %0d u %0d v %0d upd %0d, got %0d %0d %0d %0d",
                       $time, want.depth, want.u, want.v, want.updated,
                       got.depth, got.u, got.v, got.updated);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        project_item(in_ch.cmd, longint'(in_ch.pos_x), longint'(in_ch.pos_y),
                     longint'(in_ch.pos_z), int'(in_ch.read_row), int'(in_ch.read_col), want);
        pixel_queue.insert(pixel_queue.size(), want);
      end
    end
    mismatch_count <= errs;
    outstanding <= pixel_queue.size();
  end
endmodule

// ===== sim/tb_point_cloud_depth_projection_unit.sv =====
// Testbench top: clock, reset, register setup, item stimulus, receiver stalls and verdict.
module tb_point_cloud_depth_projection_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cpdp_pkg::*;

  localparam int IDLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 155;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int fail_count, in_flight;
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  logic [7:0] stall_mask = 8'hFF;
  logic [LEN_W-1:0] lx, ly, lz;

  cpdp_in_if in_ch();
  cpdp_out_if out_ch();

  always #6 clk = ~clk;

  point_cloud_depth_projection_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cpdp_depth_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_count(fail_count), .outstanding(in_flight)
  );

  // The receiver steps through the bits of an eight-bit stall mask, which is redrawn at random.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 512 == 0)
      stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    out_ch.ready = stall_mask[rx_cycle % 8];
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("point_cloud_depth_projection_unit regression: fail");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = PADDR_W'(r) << 2; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Sends one beat; valid stays high within a burst and drops for the gap after it.
  task automatic send_beat(input cmd_t c, input int x, input int y, input int z,
                           input int row, input int col);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.cmd = c;
    in_ch.pos_x = x[POS_W-1:0];
    in_ch.pos_y = y[POS_W-1:0];
    in_ch.pos_z = z[POS_W-1:0];
    in_ch.read_row = row[PIX_W-1:0];
    in_ch.read_col = col[PIX_W-1:0];
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (in_flight != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // A coordinate a little beyond half the box length either side of the centre.
  function automatic int near_box(logic [LEN_W-1:0] len);
    int span;
    span = int'(len) / 8 * 5 + 1;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic int any_pos();
    return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 3))
      0: return LEN_W'($urandom_range(1, LEN_MAX));
      1: return LEN_W'($urandom_range(16, 512));
      default: return LEN_W'($urandom_range(1024, 65536));
    endcase
  endfunction

  initial begin
    int r;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.cmd = CMD_CLEAR;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.read_row = '0; in_ch.read_col = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Points and joints before any clear see a zero-sized region.
    send_beat(CMD_POINT, 8388607, -8388608, 8388607, 0, 0);
    send_beat(CMD_POINT, -8388608, 8388607, -8388608, 0, 0);
    send_beat(CMD_JOINT, 8388607, 8388607, 0, 0, 0);
    send_beat(CMD_READ, 0, 0, 0, 0, 0);
    send_beat(CMD_READ, 0, 0, 0, 127, 127);
    send_beat(CMD_CLEAR, 0, 0, 0, 0, 0);
    send_beat(CMD_POINT, 0, 0, 0, 0, 0);
    send_beat(CMD_POINT, 0, 0, -1024, 0, 0);
    send_beat(CMD_POINT, 0, 0, 1024, 0, 0);
    send_beat(CMD_POINT, 2048, -2048, -2048, 0, 0);
    send_beat(CMD_POINT, -2048, 2048, 2047, 0, 0);
    send_beat(CMD_POINT, 8388607, 8388607, -8388608, 0, 0);
    send_beat(CMD_POINT, -8388608, -8388608, 8388607, 0, 0);
    send_beat(CMD_JOINT, 8388607, -8388608, 0, 0, 0);
    send_beat(CMD_JOINT, -8388608, 8388607, 0, 0, 0);
    send_beat(CMD_JOINT, 0, 0, 0, 0, 0);
    send_beat(CMD_READ, 0, 0, 0, 64, 64);
    send_beat(CMD_READ, 0, 0, 0, 85, 42);
    send_beat(CMD_READ, 0, 0, 0, 42, 85);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lx = 1; ly = 1; lz = 1; end
        1: begin lx = LEN_MAX; ly = LEN_MAX; lz = LEN_MAX; end
        2: begin lx = '0; ly = 4096; lz = '0; end
        3: begin lx = 1; ly = LEN_MAX; lz = 300; end
        default: begin lx = pick_len(); ly = pick_len(); lz = pick_len(); end
      endcase
      reg_write(REG_VIEW, (ph < 4) ? ph : $urandom_range(0, 3));
      reg_write(REG_LEN_X, PDATA_W'(lx));
      reg_write(REG_LEN_Y, PDATA_W'(ly));
      reg_write(REG_LEN_Z, PDATA_W'(lz));
      case (ph)
        0: reg_write(REG_SIZE, 16);
        1: reg_write(REG_SIZE, 128);
        2: reg_write(REG_SIZE, 0);
        3: reg_write(REG_SIZE, 255);
        default: reg_write(REG_SIZE, ($urandom_range(0, 1) == 0) ?
                                      $urandom_range(16, 40) : $urandom_range(0, 255));
      endcase
      // Now and then the region of the previous clear is kept under the new registers.
      if (ph < 4 || $urandom_range(0, 5) != 0)
        send_beat(CMD_CLEAR, any_pos(), any_pos(), any_pos(), 0, 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        if (r < 62)
          send_beat(CMD_POINT, near_box(lx), near_box(ly), near_box(lz),
                    $urandom_range(0, 127), $urandom_range(0, 127));
        else if (r < 72)
          send_beat(CMD_POINT, any_pos(), any_pos(), any_pos(),
                    $urandom_range(0, 127), $urandom_range(0, 127));
        else if (r < 84)
          send_beat(CMD_JOINT, (r < 80) ? near_box(lx) : any_pos(),
                    (r < 80) ? near_box(ly) : any_pos(), any_pos(),
                    $urandom_range(0, 127), $urandom_range(0, 127));
        else
          send_beat(CMD_READ, any_pos(), any_pos(), any_pos(),
                    $urandom_range(0, 127), $urandom_range(0, 127));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("point_cloud_depth_projection_unit regression: pass");
    end else begin
      $display("point_cloud_depth_projection_unit regression: fail");
    end
    $finish;
  end
endmodule

// ===== point_cloud_depth_projection_unit.f =====
hw/rtl/cpdp_pkg.sv
hw/rtl/cpdp_if.sv
hw/rtl/cpdp_ram.sv
hw/rtl/cpdp_div.sv
hw/rtl/cpdp_ctrl.sv
hw/rtl/cpdp_dp.sv
hw/rtl/point_cloud_depth_projection_unit.sv
sim/cpdp_depth_checker.sv
sim/tb_point_cloud_depth_projection_unit.sv
